// ===== rtl/core/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT   = 2'd1;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd2;

  localparam int unsigned PADDR_W = 4;

  // Register reset values.
  localparam logic [31:0] HEAP_BASE_RESET    = 32'd0;
  localparam logic [31:0] HEAP_LIMIT_RESET   = 32'd65536;
  localparam logic [7:0]  HEADER_BYTES_RESET = 8'd24;

  // Kind of search a token performs as it walks the cell chain.
  typedef enum logic {
    SRCH_LIVE,
    SRCH_FREE
  } srch_e_t;

  // Update that the controller broadcasts to one cell.
  typedef enum logic [1:0] {
    WR_NONE,
    WR_FILL,
    WR_SET_FREE,
    WR_CLR_FREE
  } wr_op_t;

  typedef struct packed {
    wr_op_t      op;
    logic [31:0] addr;
    logic [31:0] size;
  } wr_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic        valid;
    srch_e_t     mode;
    logic        hit;
    logic [31:0] key;
    logic [31:0] hit_addr;
    logic [31:0] hit_size;
  } tok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_GROW,
    S_TAKE,
    S_FREE_OLD,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffba_cmd_if.sv =====
`default_nettype none
interface ffba_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] request_bytes;
  logic [31:0] block_address;

  modport source (output valid, output command, output request_bytes,
                  output block_address, input ready);
  modport sink (input valid, input command, input request_bytes,
                input block_address, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ffba_rsp_if.sv =====
`default_nettype none
interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [1:0]  status;
  logic [31:0] copy_bytes;

  modport source (output valid, output result_address, output status,
                  output copy_bytes, input ready);
  modport sink (input valid, input result_address, input status,
                input copy_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ffba_cell.sv =====
`default_nettype none
module ffba_cell #(
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7,
  parameter int CELL_INDEX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [CNT_W-1:0]  count,
  input  wire ffba_pkg::wr_t     wr,
  input  wire logic [IDX_W-1:0]  wr_index,
  input  wire ffba_pkg::tok_t    tok_in,
  input  wire logic [IDX_W-1:0]  idx_in,
  output ffba_pkg::tok_t         tok_out,
  output logic [IDX_W-1:0]       idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);

  // One table entry.
  logic [31:0] addr_q;
  logic [31:0] size_q;
  logic        free_q;

  logic used;
  logic match;
  logic wr_here;

  assign used    = MY_CNT < count;
  assign wr_here = wr_index == MY_IDX;

  // An entry claims the token when it is the first one to satisfy the search.
  always_comb begin
    match = 1'b0;
    if (tok_in.valid && !tok_in.hit && used) begin
      if (tok_in.mode == ffba_pkg::SRCH_FREE) begin
        match = free_q && (size_q >= tok_in.key);
      end else begin
        match = !free_q && (addr_q == tok_in.key);
      end
    end
  end

  // Entry updates from the controller.
  always_ff @(posedge clk) begin
    if (wr_here) begin
      unique case (wr.op)
        ffba_pkg::WR_FILL: begin
          addr_q <= wr.addr;
          size_q <= wr.size;
          free_q <= 1'b0;
        end
        ffba_pkg::WR_SET_FREE: free_q <= 1'b1;
        ffba_pkg::WR_CLR_FREE: free_q <= 1'b0;
        ffba_pkg::WR_NONE: ;
      endcase
    end
  end

  // Token stage toward the next cell; only the valid bit needs a reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.mode <= tok_in.mode;
    tok_out.key  <= tok_in.key;
    if (match) begin
      tok_out.hit      <= 1'b1;
      tok_out.hit_addr <= addr_q;
      tok_out.hit_size <= size_q;
      idx_out          <= MY_IDX;
    end else begin
      tok_out.hit      <= tok_in.hit;
      tok_out.hit_addr <= tok_in.hit_addr;
      tok_out.hit_size <= tok_in.hit_size;
      idx_out          <= idx_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ffba_ctrl.sv =====
`default_nettype none
module ffba_ctrl #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  ffba_cmd_if.sink                               cmd,
  ffba_rsp_if.source                             rsp,
  input  wire logic [31:0]                       heap_limit,
  input  wire logic [7:0]                        header_bytes,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]        count,
  output ffba_pkg::wr_t                          wr,
  output logic [$clog2(MAX_BLOCKS)-1:0]          wr_index,
  output ffba_pkg::tok_t                         inject,
  input  wire ffba_pkg::tok_t                    tail,
  input  wire logic [$clog2(MAX_BLOCKS)-1:0]     tail_idx
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_BLOCKS);

  ffba_pkg::state_t state, state_next;

  // Latched command word.
  logic [1:0]  cmd_q;
  logic [31:0] req_q;
  logic [31:0] addr_q;

  ffba_pkg::srch_e_t srch_mode;
  logic [IDX_W-1:0]  old_idx;
  logic [31:0]       old_size;
  logic [IDX_W-1:0]  hit_idx;

  logic [31:0] res_addr;
  logic [1:0]  res_st;
  logic [31:0] res_copy;

  logic [31:0] heap_top;

  logic        rsp_valid;
  logic [31:0] rsp_addr;
  logic [1:0]  rsp_st;
  logic [31:0] rsp_copy;

  logic        accept;
  logic        rsp_load;
  logic [33:0] grow_end;
  logic [31:0] grow_addr;
  logic        grow_fits;
  logic        grow_commit;

  assign accept   = cmd.valid && cmd.ready;
  assign rsp_load = (state == ffba_pkg::S_DONE) && (!rsp_valid || rsp.ready);

  // Heap growth is checked in 34 bits so that no sum wraps.
  assign grow_end    = {2'b00, heap_top} + {26'd0, header_bytes} + {2'b00, req_q};
  assign grow_addr   = heap_top + {24'd0, header_bytes};
  assign grow_fits   = (count != FULL) && (grow_end <= {2'b00, heap_limit});
  assign grow_commit = (state == ffba_pkg::S_GROW) && grow_fits;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ffba_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd.command == ffba_pkg::CMD_ALLOC) begin
            state_next = (cmd.request_bytes == 32'd0) ? ffba_pkg::S_DONE : ffba_pkg::S_LAUNCH;
          end else if ((cmd.command == ffba_pkg::CMD_FREE) ||
                       (cmd.command == ffba_pkg::CMD_REALLOC)) begin
            state_next = (cmd.block_address == 32'd0) ? ffba_pkg::S_DONE : ffba_pkg::S_LAUNCH;
          end else begin
            state_next = ffba_pkg::S_DONE;
          end
        end
      end
      ffba_pkg::S_LAUNCH: state_next = ffba_pkg::S_WAIT;
      ffba_pkg::S_WAIT: begin
        if (tail.valid) begin
          if (srch_mode == ffba_pkg::SRCH_LIVE) begin
            if (!tail.hit) begin
              state_next = ffba_pkg::S_DONE;
            end else if (cmd_q == ffba_pkg::CMD_FREE || req_q == 32'd0) begin
              state_next = ffba_pkg::S_FREE_OLD;
            end else if (tail.hit_size >= req_q) begin
              state_next = ffba_pkg::S_DONE;
            end else begin
              state_next = ffba_pkg::S_LAUNCH;
            end
          end else begin
            state_next = tail.hit ? ffba_pkg::S_TAKE : ffba_pkg::S_GROW;
          end
        end
      end
      ffba_pkg::S_GROW: begin
        if (grow_fits && cmd_q == ffba_pkg::CMD_REALLOC) begin
          state_next = ffba_pkg::S_FREE_OLD;
        end else begin
          state_next = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_TAKE: begin
        state_next = (cmd_q == ffba_pkg::CMD_REALLOC) ? ffba_pkg::S_FREE_OLD : ffba_pkg::S_DONE;
      end
      ffba_pkg::S_FREE_OLD: state_next = ffba_pkg::S_DONE;
      ffba_pkg::S_DONE: begin
        if (rsp_load) begin
          state_next = ffba_pkg::S_IDLE;
        end
      end
      default: state_next = ffba_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshake, token injection and entry updates.
  always_comb begin
    cmd.ready       = state == ffba_pkg::S_IDLE;
    inject.valid    = state == ffba_pkg::S_LAUNCH;
    inject.mode     = srch_mode;
    inject.hit      = 1'b0;
    inject.key      = (srch_mode == ffba_pkg::SRCH_FREE) ? req_q : addr_q;
    inject.hit_addr = 32'd0;
    inject.hit_size = 32'd0;
    wr.op           = ffba_pkg::WR_NONE;
    wr.addr         = grow_addr;
    wr.size         = req_q;
    wr_index        = old_idx;
    unique case (state)
      ffba_pkg::S_GROW: begin
        wr_index = count[IDX_W-1:0];
        if (grow_fits) begin
          wr.op = ffba_pkg::WR_FILL;
        end
      end
      ffba_pkg::S_TAKE: begin
        wr_index = hit_idx;
        wr.op    = ffba_pkg::WR_CLR_FREE;
      end
      ffba_pkg::S_FREE_OLD: wr.op = ffba_pkg::WR_SET_FREE;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffba_pkg::S_IDLE;
      count     <= '0;
      heap_top  <= ffba_pkg::HEAP_BASE_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (grow_commit) begin
        count    <= count + CNT_W'(1);
        heap_top <= grow_end[31:0];
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Command data path.
  always_ff @(posedge clk) begin
    unique case (state)
      ffba_pkg::S_IDLE: begin
        if (accept) begin
          cmd_q    <= cmd.command;
          req_q    <= cmd.request_bytes;
          addr_q   <= cmd.block_address;
          res_addr <= 32'd0;
          res_copy <= 32'd0;
          res_st   <= ffba_pkg::ST_UNKNOWN;
          if (cmd.command == ffba_pkg::CMD_ALLOC) begin
            srch_mode <= ffba_pkg::SRCH_FREE;
            if (cmd.request_bytes == 32'd0) begin
              res_st <= ffba_pkg::ST_ZERO;
            end
          end else begin
            srch_mode <= ffba_pkg::SRCH_LIVE;
          end
        end
      end
      ffba_pkg::S_WAIT: begin
        if (tail.valid && tail.hit) begin
          if (srch_mode == ffba_pkg::SRCH_LIVE) begin
            old_idx  <= tail_idx;
            old_size <= tail.hit_size;
            if (cmd_q == ffba_pkg::CMD_FREE) begin
              res_st <= ffba_pkg::ST_OK;
            end else if (req_q == 32'd0) begin
              res_st <= ffba_pkg::ST_ZERO;
            end else if (tail.hit_size >= req_q) begin
              res_addr <= addr_q;
              res_st   <= ffba_pkg::ST_OK;
            end else begin
              srch_mode <= ffba_pkg::SRCH_FREE;
            end
          end else begin
            hit_idx  <= tail_idx;
            res_addr <= tail.hit_addr;
            res_st   <= ffba_pkg::ST_OK;
            res_copy <= (cmd_q == ffba_pkg::CMD_REALLOC) ? old_size : 32'd0;
          end
        end
      end
      ffba_pkg::S_GROW: begin
        if (grow_fits) begin
          res_addr <= grow_addr;
          res_st   <= ffba_pkg::ST_OK;
          res_copy <= (cmd_q == ffba_pkg::CMD_REALLOC) ? old_size : 32'd0;
        end else begin
          res_addr <= 32'd0;
          res_st   <= ffba_pkg::ST_NOSPACE;
          res_copy <= 32'd0;
        end
      end
      default: ;
    endcase
  end

  // Output register, so a new command can be taken while a result waits.
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_addr <= res_addr;
      rsp_st   <= res_st;
      rsp_copy <= res_copy;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.result_address = rsp_addr;
  assign rsp.status         = rsp_st;
  assign rsp.copy_bytes     = rsp_copy;

  // A token leaves the chain only while the controller waits for it.
  a_tail_in_wait: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> state == ffba_pkg::S_WAIT)
    else $error("search token left the chain outside the wait state");

  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count exceeds table size");

  // The heap top only grows, and only together with a new entry.
  a_top_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (heap_top != $past(heap_top)) |->
      (heap_top > $past(heap_top)) && (count == $past(count) + CNT_W'(1)))
    else $error("heap top moved without appending an entry");

  // A result is only loaded once the command is finished.
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    rsp_load |=> rsp_valid && state == ffba_pkg::S_IDLE)
    else $error("result load did not return to idle");

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_block_allocator.sv =====
`default_nettype none
// Channel   Direction  Words carried
// cmd       in         command, request_bytes, block_address
// rsp       out        result_address, status, copy_bytes
// apb       in/out     heap_base (0x0), heap_limit (0x4), header_bytes (0x8)
//
// A search token walks the row of MAX_BLOCKS cells one cell per cycle.
// Allocate and free run one table search each, an in-place reallocate one,
// a relocating reallocate two (a live search, then a free search).
// Zero-size allocates, null addresses and command three answer without a table search.
// Reset empties the table at once; there is no clearing pass.
// A new command is taken while the previous result waits in the output register.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ffba_cmd_if.sink                            cmd,
  ffba_rsp_if.source                          rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ffba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  logic [31:0] heap_base;
  logic [31:0] heap_limit;
  logic [7:0]  header_bytes;
  logic [1:0]  reg_idx;
  logic        reg_wr;

  logic [CNT_W-1:0] count;
  ffba_pkg::wr_t    wr;
  logic [IDX_W-1:0] wr_index;

  ffba_pkg::tok_t   tok [MAX_BLOCKS+1];
  logic [IDX_W-1:0] idx [MAX_BLOCKS+1];

  // Configuration registers.
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base    <= ffba_pkg::HEAP_BASE_RESET;
      heap_limit   <= ffba_pkg::HEAP_LIMIT_RESET;
      header_bytes <= ffba_pkg::HEADER_BYTES_RESET;
    end else if (reg_wr) begin
      unique case (reg_idx)
        ffba_pkg::REG_HEAP_BASE:    heap_base    <= pwdata;
        ffba_pkg::REG_HEAP_LIMIT:   heap_limit   <= pwdata;
        ffba_pkg::REG_HEADER_BYTES: header_bytes <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ffba_pkg::REG_HEAP_BASE:    prdata = heap_base;
      ffba_pkg::REG_HEAP_LIMIT:   prdata = heap_limit;
      ffba_pkg::REG_HEADER_BYTES: prdata = {24'd0, header_bytes};
      default:                    prdata = 32'd0;
    endcase
  end

  ffba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rsp          (rsp),
    .heap_limit   (heap_limit),
    .header_bytes (header_bytes),
    .count        (count),
    .wr           (wr),
    .wr_index     (wr_index),
    .inject       (tok[0]),
    .tail         (tok[MAX_BLOCKS]),
    .tail_idx     (idx[MAX_BLOCKS])
  );

  assign idx[0] = '0;

  // Row of table cells; the token moves one cell per cycle.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffba_cell #(
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .wr       (wr),
      .wr_index (wr_index),
      .tok_in   (tok[i]),
      .idx_in   (idx[i]),
      .tok_out  (tok[i+1]),
      .idx_out  (idx[i+1])
    );
  end

endmodule
`default_nettype wire
